### sv/tdf_pkg.sv
// Shared types and constants for the trial-division factorizer.
package tdf_pkg;
   localparam int STATUS_BITS = 2;
   localparam logic [STATUS_BITS-1:0] STATUS_COMPOSITE = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_PRIME     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID   = 2'd2;
   localparam int PF_BITS    = 31;
   localparam int SMALL_BITS = 16;
   localparam int LDIV_BITS  = 30;
   localparam int LPF_BITS   = 30;
   localparam int STORE_DEPTH = 31;
   localparam int COUNT_BITS  = 5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TEST, ST_DIV, ST_EMIT, ST_QDIV, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DV_IDLE, DV_RUN, DV_DONE
   } div_state_type;
endpackage

### sv/tdf_fifo.sv
// Small request queue between the accept side and the factoring engine.
module tdf_fifo #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != CW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count step");
`endif
endmodule

### sv/tdf_div.sv
// Restoring divider, one quotient bit per cycle.
module tdf_div #(
   parameter int W = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   import tdf_pkg::*;
   localparam int CW = $clog2(W + 1);

   div_state_type    st_ff, st_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [W-1:0]     q_ff, q_in, d_ff, d_in;
   logic [W:0]       r_ff, r_in, trial;

   assign trial = {r_ff[W-1:0], q_ff[W-1]} - {1'b0, d_ff};

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         DV_IDLE: if (start) st_in = DV_RUN;
         DV_RUN:  if (cnt_ff == CW'(1)) st_in = DV_DONE;
         DV_DONE: st_in = start ? DV_RUN : DV_IDLE;
         default: st_in = DV_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      if (start && st_ff != DV_RUN) begin
         cnt_in = CW'(W);
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
      end else if (st_ff == DV_RUN) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[W]) begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-1:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DV_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = (st_ff == DV_DONE);
   assign quotient = q_ff;
   assign remainder = r_ff[W-1:0];

`ifndef NO_ASSERTIONS
   a_done_follows_run: assert property (@(posedge clock) disable iff (reset)
      $rose(done) |-> $past(st_ff) == DV_RUN) else $error("done without run");
   a_cnt_run: assert property (@(posedge clock) disable iff (reset)
      st_ff == DV_RUN |-> cnt_ff != '0) else $error("run with zero count");
   a_no_start_run: assert property (@(posedge clock) disable iff (reset)
      st_ff == DV_RUN |-> !start) else $error("start while busy");
`endif
endmodule

### sv/tdf_engine.sv
// Factoring engine: trial division loop, factor store and result emission.
module tdf_engine #(
   parameter int VALUE_BITS = 31
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [VALUE_BITS-1:0]           in_number,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [tdf_pkg::STATUS_BITS-1:0] out_status,
   output logic [tdf_pkg::PF_BITS-1:0]     out_pf,
   output logic [tdf_pkg::SMALL_BITS-1:0]  out_small,
   output logic [tdf_pkg::LDIV_BITS-1:0]   out_ldiv,
   output logic [tdf_pkg::LPF_BITS-1:0]    out_lpf,
   output logic                            out_last
);
   import tdf_pkg::*;
   localparam int W = VALUE_BITS;

   state_type          st_ff, st_in;
   logic [W-1:0]       n_ff, rem_ff, d_ff, small_ff, lpf_ff, ldiv_ff;
   logic [W-1:0]       n_in, rem_in, d_in, small_in, lpf_in, ldiv_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, rd_ff, rd_in;
   logic [PF_BITS-1:0] store_ff [STORE_DEPTH];
   logic               wr_en;
   logic [PF_BITS-1:0] wr_data;
   logic               div_start, div_done;
   logic [W-1:0]       div_a, div_b, div_q, div_r;
   logic               prime_ff, prime_in;
   logic [STATUS_BITS-1:0] ostat_ff, ostat_in;
   logic [PF_BITS-1:0] opf_ff, opf_in;
   logic               olast_ff, olast_in;
   logic               ov_ff, ov_in;
   logic               room;

   tdf_div #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign room = !ov_ff || out_ready;
   assign in_ready = (st_ff == ST_IDLE) && room;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (in_valid && room) st_in = (in_number == '0) ? ST_OUT : ST_TEST;
         ST_TEST: if (div_done) begin
            if (div_q < d_ff) st_in = ST_EMIT;
            else if (div_r == '0) st_in = ST_DIV;
         end
         ST_DIV:  st_in = ST_TEST;
         ST_EMIT: st_in = prime_ff ? ST_OUT : ST_QDIV;
         ST_QDIV: if (div_done) st_in = ST_OUT;
         ST_OUT:  if (room && (prime_ff || rd_ff + 1'b1 >= cnt_ff)) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_a = rem_ff;
      div_b = d_ff;
      case (st_ff)
         ST_IDLE: begin
            div_start = in_valid && room && in_number != '0;
            div_a = in_number;
            div_b = W'(2);
         end
         ST_TEST: begin
            if (div_done && div_q >= d_ff) begin
               div_start = 1'b1;
               if (div_r == '0) begin
                  div_a = div_q;
               end else begin
                  div_b = d_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            div_start = !prime_ff;
            div_a = n_ff;
            div_b = small_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   always_comb begin
      n_in = n_ff; rem_in = rem_ff; d_in = d_ff; small_in = small_ff;
      lpf_in = lpf_ff; ldiv_in = ldiv_ff; cnt_in = cnt_ff; rd_in = rd_ff;
      prime_in = prime_ff; wr_en = 1'b0; wr_data = PF_BITS'(d_ff);
      ostat_in = ostat_ff; opf_in = opf_ff; olast_in = olast_ff;
      ov_in = ov_ff && !out_ready;
      case (st_ff)
         ST_IDLE: if (in_valid && room) begin
            n_in = in_number; rem_in = in_number; d_in = W'(2);
            small_in = '0; lpf_in = '0; ldiv_in = '0; cnt_in = '0; rd_in = '0;
            prime_in = 1'b0;
            if (in_number == '0) begin
               prime_in = 1'b1; n_in = '0;
            end
         end
         ST_TEST: if (div_done && div_q >= d_ff) begin
            if (div_r == '0) begin
               rem_in = div_q;
               if (small_ff == '0) small_in = d_ff;
               lpf_in = d_ff;
               if (cnt_ff < COUNT_BITS'(STORE_DEPTH)) begin
                  wr_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (small_ff == '0) begin
               prime_in = 1'b1;
            end else if (rem_ff > W'(1)) begin
               lpf_in = rem_ff;
               wr_data = PF_BITS'(rem_ff);
               if (cnt_ff < COUNT_BITS'(STORE_DEPTH)) begin
                  wr_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_QDIV: if (div_done) ldiv_in = div_q;
         ST_OUT: if (room) begin
            ov_in = 1'b1;
            if (prime_ff) begin
               olast_in = 1'b1;
               if (n_ff != '0) begin
                  ostat_in = STATUS_PRIME; opf_in = PF_BITS'(n_ff);
               end else begin
                  ostat_in = STATUS_INVALID; opf_in = '0;
               end
            end else begin
               ostat_in = STATUS_COMPOSITE;
               opf_in = store_ff[rd_ff];
               olast_in = (rd_ff + 1'b1 >= cnt_ff);
               rd_in = rd_ff + 1'b1;
            end
         end
         default: ov_in = ov_ff && !out_ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         cnt_ff <= '0;
         rd_ff <= '0;
         prime_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         prime_ff <= prime_in;
      end
      n_ff <= n_in; rem_ff <= rem_in; d_ff <= d_in; small_ff <= small_in;
      lpf_ff <= lpf_in; ldiv_ff <= ldiv_in;
      ostat_ff <= ostat_in; opf_ff <= opf_in; olast_ff <= olast_in;
      if (wr_en) begin
         store_ff[cnt_ff] <= wr_data;
      end
   end

   assign out_valid = ov_ff;
   assign out_status = ostat_ff;
   assign out_pf = opf_ff;
   assign out_last = olast_ff;
   assign out_small = (ostat_ff == STATUS_COMPOSITE) ? SMALL_BITS'(small_ff) : '0;
   assign out_ldiv = (ostat_ff == STATUS_COMPOSITE) ? LDIV_BITS'(ldiv_ff) : '0;
   assign out_lpf = (ostat_ff == STATUS_COMPOSITE) ? LPF_BITS'(lpf_ff) : '0;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_BITS'(STORE_DEPTH)) else $error("store count overflow");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |-> st_ff == ST_IDLE) else $error("accept while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(out_pf))
      else $error("result dropped");
`endif
endmodule

### sv/trial_division_factorizer.sv
// Top level of the trial-division factorizer.
// Each request is one number; the result stream gives one item for zero
// (invalid) or a prime, and one item per prime factor for a composite, with
// tlast on the final item and the status code on tuser. Requests queue in a
// two-entry buffer ahead of the factoring engine. Run time per request is
// dominated by the shared bit-serial divider, run once per trial division.
module trial_division_factorizer #(
   parameter int VALUE_BITS = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [30:0] number
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // prime_factor, smallest_factor, largest_divisor, largest_prime_factor
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast
);
   import tdf_pkg::*;

   logic                   q_valid, q_ready;
   logic [VALUE_BITS-1:0]  q_data, in_num;
   logic [PF_BITS-1:0]     o_pf;
   logic [SMALL_BITS-1:0]  o_small;
   logic [LDIV_BITS-1:0]   o_ldiv;
   logic [LPF_BITS-1:0]    o_lpf;

   always_comb begin
      in_num = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (i < 31) in_num[i] = req_tdata[i];
      end
   end

   tdf_fifo #(.WIDTH(VALUE_BITS), .DEPTH(2)) u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(in_num),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   tdf_engine #(.VALUE_BITS(VALUE_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_number(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(rsp_tuser), .out_pf(o_pf), .out_small(o_small),
      .out_ldiv(o_ldiv), .out_lpf(o_lpf), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'b0, o_lpf, o_ldiv, o_small, o_pf};
endmodule
